// ===== hdl/psv_pkg.sv =====
// shared types and constants for the prime sieve table
package psv_pkg;

   localparam int FIELD_W = 13;
   localparam int WORD_W  = 16;
   localparam int BIT_W   = 4;

   localparam logic MODE_BUILD = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // zero and one are not prime, every other bit starts as a candidate
   localparam logic [WORD_W-1:0] WORD_INIT_LOW = 16'hFFFC;
   localparam logic [WORD_W-1:0] WORD_INIT     = 16'hFFFF;

   typedef struct packed {
      logic cap_build;
      logic cap_query;
      logic init_wr;
      logic chk_rd;
      logic chk_next;
      logic str_start;
      logic str_rd;
      logic str_wr;
      logic q_rd;
      logic q_next;
      logic fin_build;
      logic fin_query;
      logic fin_oor;
   } cmd_type;

   typedef struct packed {
      logic q_oor;
      logic init_last;
      logic sq_over;
      logic i_bit;
      logic j_over;
      logic q_hit;
      logic q_bottom;
   } stat_type;

endpackage

// ===== hdl/psv_control.sv =====
// sequencer for sieve build and prime query requests
module psv_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_mode,
   input  psv_pkg::stat_type  stat,
   output psv_pkg::cmd_type   cmd,
   output logic               busy,
   output logic               rsp_valid
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INIT   = 3'd1;
   localparam logic [2:0] ST_CHK_RD = 3'd2;
   localparam logic [2:0] ST_CHK_EV = 3'd3;
   localparam logic [2:0] ST_STR_RD = 3'd4;
   localparam logic [2:0] ST_STR_WR = 3'd5;
   localparam logic [2:0] ST_Q_RD   = 3'd6;
   localparam logic [2:0] ST_Q_EV   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_mode == psv_pkg::MODE_BUILD) begin
                  cmd.cap_build = 1'b1;
                  state_in      = ST_INIT;
               end else if (stat.q_oor) begin
                  cmd.fin_oor = 1'b1;
               end else begin
                  cmd.cap_query = 1'b1;
                  state_in      = ST_Q_RD;
               end
            end
         end
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (stat.init_last) begin
               state_in = ST_CHK_RD;
            end
         end
         ST_CHK_RD: begin
            if (stat.sq_over) begin
               cmd.fin_build = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.chk_rd = 1'b1;
               state_in   = ST_CHK_EV;
            end
         end
         ST_CHK_EV: begin
            if (stat.i_bit) begin
               cmd.str_start = 1'b1;
               state_in      = ST_STR_RD;
            end else begin
               cmd.chk_next = 1'b1;
               state_in     = ST_CHK_RD;
            end
         end
         ST_STR_RD: begin
            if (stat.j_over) begin
               cmd.chk_next = 1'b1;
               state_in     = ST_CHK_RD;
            end else begin
               cmd.str_rd = 1'b1;
               state_in   = ST_STR_WR;
            end
         end
         ST_STR_WR: begin
            cmd.str_wr = 1'b1;
            state_in   = ST_STR_RD;
         end
         ST_Q_RD: begin
            cmd.q_rd = 1'b1;
            state_in = ST_Q_EV;
         end
         ST_Q_EV: begin
            if (stat.q_hit || stat.q_bottom) begin
               cmd.fin_query = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.q_next = 1'b1;
               state_in   = ST_Q_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.fin_build || cmd.fin_query || cmd.fin_oor;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("response strobe outside idle");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid_ff)
      else $error("accepted request neither started nor answered");

endmodule

// ===== hdl/psv_datapath.sv =====
// bitmap memory, sieve counters and query scan for the prime sieve table
module psv_datapath #(
   parameter int MAX_N = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [psv_pkg::FIELD_W-1:0]       req_limit,
   input  logic [psv_pkg::FIELD_W-1:0]       req_value,
   input  psv_pkg::cmd_type                  cmd,
   output psv_pkg::stat_type                 stat,
   output logic                              rsp_done_res,
   output logic                              rsp_is_prime_flag,
   output logic [psv_pkg::FIELD_W-1:0]       rsp_prev_prime,
   output logic                              rsp_out_of_range
);

   localparam int WORD_W  = psv_pkg::WORD_W;
   localparam int BIT_W   = psv_pkg::BIT_W;
   localparam int FIELD_W = psv_pkg::FIELD_W;
   localparam int IW      = ($clog2(MAX_N + 1) > BIT_W) ? $clog2(MAX_N + 1) : BIT_W + 1;
   localparam int WAW     = IW - BIT_W;
   localparam int NWORDS  = MAX_N / WORD_W + 1;

   function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_W-1:0] word);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int b = 0; b < WORD_W; b++) begin
         if (word[b]) begin
            pos = BIT_W'(b);
         end
      end
      return pos;
   endfunction

   logic [WORD_W-1:0] mem [NWORDS];
   logic [WORD_W-1:0] rdata_ff;

   logic [IW-1:0]     lim_ff, lim_in;
   logic [IW-1:0]     built_limit_ff, built_limit_in;
   logic              built_valid_ff, built_valid_in;
   logic [IW-1:0]     i_ff, i_in;
   logic [IW:0]       sq_ff, sq_in;
   logic [IW:0]       j_ff, j_in;
   logic [WAW-1:0]    w_ff, w_in;
   logic [BIT_W-1:0]  vlo_ff, vlo_in;
   logic              first_ff, first_in;
   logic              isp_ff, isp_in;
   logic              done_ff, done_in;
   logic              prime_ff, prime_in;
   logic [FIELD_W-1:0] prev_ff, prev_in;
   logic              oor_ff, oor_in;

   logic [IW-1:0]     lim_sat;
   logic [IW-1:0]     val_iw;
   logic [WORD_W-1:0] lo_mask;
   logic [WORD_W-1:0] masked;
   logic [BIT_W-1:0]  hit_pos;
   logic              cur_bit;

   logic              mem_we;
   logic [WAW-1:0]    mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic              mem_re;
   logic [WAW-1:0]    mem_raddr;

   always_comb begin
      if (32'(req_limit) > 32'(MAX_N)) begin
         lim_sat = IW'(MAX_N);
      end else begin
         lim_sat = IW'(req_limit);
      end
   end

   assign val_iw  = IW'(req_value);
   assign lo_mask = WORD_W'((32'd2 << vlo_ff) - 32'd1);
   assign masked  = rdata_ff & (first_ff ? lo_mask : {WORD_W{1'b1}});
   assign hit_pos = top_bit(masked);
   assign cur_bit = rdata_ff[vlo_ff];

   assign stat.q_oor     = !built_valid_ff || (32'(req_value) > 32'(built_limit_ff));
   assign stat.init_last = (w_ff == lim_ff[IW-1:BIT_W]);
   assign stat.sq_over   = (sq_ff > {1'b0, lim_ff});
   assign stat.i_bit     = rdata_ff[i_ff[BIT_W-1:0]];
   assign stat.j_over    = (j_ff > {1'b0, lim_ff});
   assign stat.q_hit     = |masked;
   assign stat.q_bottom  = (w_ff == '0);

   // memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = w_ff;
      mem_wdata = psv_pkg::WORD_INIT;
      if (cmd.init_wr) begin
         mem_we    = 1'b1;
         mem_wdata = (w_ff == '0) ? psv_pkg::WORD_INIT_LOW : psv_pkg::WORD_INIT;
      end else if (cmd.str_wr) begin
         mem_we    = 1'b1;
         mem_waddr = j_ff[IW-1:BIT_W];
         mem_wdata = rdata_ff & ~(WORD_W'(1) << j_ff[BIT_W-1:0]);
      end
   end

   always_comb begin
      mem_re    = cmd.chk_rd || cmd.str_rd || cmd.q_rd;
      mem_raddr = w_ff;
      if (cmd.chk_rd) begin
         mem_raddr = i_ff[IW-1:BIT_W];
      end else if (cmd.str_rd) begin
         mem_raddr = j_ff[IW-1:BIT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // next state of counters and results
   always_comb begin
      lim_in         = lim_ff;
      built_limit_in = built_limit_ff;
      built_valid_in = built_valid_ff;
      i_in           = i_ff;
      sq_in          = sq_ff;
      j_in           = j_ff;
      w_in           = w_ff;
      vlo_in         = vlo_ff;
      first_in       = first_ff;
      isp_in         = isp_ff;
      done_in        = done_ff;
      prime_in       = prime_ff;
      prev_in        = prev_ff;
      oor_in         = oor_ff;

      if (cmd.cap_build) begin
         lim_in = lim_sat;
         w_in   = '0;
         i_in   = IW'(2);
         sq_in  = (IW + 1)'(4);
      end
      if (cmd.cap_query) begin
         w_in     = val_iw[IW-1:BIT_W];
         vlo_in   = val_iw[BIT_W-1:0];
         first_in = 1'b1;
      end
      if (cmd.init_wr) begin
         w_in = w_ff + WAW'(1);
      end
      if (cmd.chk_next) begin
         i_in  = i_ff + IW'(1);
         sq_in = sq_ff + {i_ff, 1'b1};
      end
      if (cmd.str_start) begin
         j_in = sq_ff;
      end
      if (cmd.str_wr) begin
         j_in = j_ff + {1'b0, i_ff};
      end
      if (cmd.q_next) begin
         if (first_ff) begin
            isp_in = cur_bit;
         end
         first_in = 1'b0;
         w_in     = w_ff - WAW'(1);
      end
      if (cmd.fin_build) begin
         built_limit_in = lim_ff;
         built_valid_in = 1'b1;
         done_in        = 1'b1;
         prime_in       = 1'b0;
         prev_in        = '0;
         oor_in         = 1'b0;
      end
      if (cmd.fin_oor) begin
         done_in  = 1'b0;
         prime_in = 1'b0;
         prev_in  = '0;
         oor_in   = 1'b1;
      end
      if (cmd.fin_query) begin
         done_in  = 1'b0;
         prime_in = first_ff ? cur_bit : isp_ff;
         prev_in  = stat.q_hit ? FIELD_W'({w_ff, hit_pos}) : '0;
         oor_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         built_limit_ff <= '0;
         built_valid_ff <= 1'b0;
      end else begin
         built_limit_ff <= built_limit_in;
         built_valid_ff <= built_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff   <= lim_in;
      i_ff     <= i_in;
      sq_ff    <= sq_in;
      j_ff     <= j_in;
      w_ff     <= w_in;
      vlo_ff   <= vlo_in;
      first_ff <= first_in;
      isp_ff   <= isp_in;
      done_ff  <= done_in;
      prime_ff <= prime_in;
      prev_ff  <= prev_in;
      oor_ff   <= oor_in;
   end

   assign rsp_done_res      = done_ff;
   assign rsp_is_prime_flag = prime_ff;
   assign rsp_prev_prime    = prev_ff;
   assign rsp_out_of_range  = oor_ff;

   a_strike_in_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.str_wr |-> j_ff <= {1'b0, lim_ff})
      else $error("strike beyond sieve limit");

   a_query_after_build: assert property (@(posedge clock) disable iff (reset)
      cmd.q_rd |-> built_valid_ff)
      else $error("bitmap read before any build");

endmodule

// ===== hdl/prime_sieve_table.sv =====
// prime sieve table top level: sieve of eratosthenes bitmap with prime queries
//
//   channel   ports                                        handshake
//   request   req_mode, req_limit, req_value               start && !busy
//   response  rsp_done_res, rsp_is_prime_flag,             rsp_valid, one cycle
//             rsp_prev_prime, rsp_out_of_range
//
// build: fills the bitmap words up to the limit, then reads each sieve index up to
//   sqrt(limit) and strikes every multiple of each prime index from its square with a
//   read-modify-write on the bitmap, then finishes
// query: scans the 16-bit bitmap words down from the value to the previous prime;
//   a query that is out of range is answered from idle without going busy
// the response strobe comes while busy is low; a new request may start then
// in the datapath reset clears the build status only; the bitmap is not cleared
// the receiver cannot stall the response
module prime_sieve_table #(
   parameter int MAX_N = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_mode,
   input  logic [psv_pkg::FIELD_W-1:0] req_limit,
   input  logic [psv_pkg::FIELD_W-1:0] req_value,
   output logic                        rsp_valid,
   output logic                        rsp_done_res,
   output logic                        rsp_is_prime_flag,
   output logic [psv_pkg::FIELD_W-1:0] rsp_prev_prime,
   output logic                        rsp_out_of_range
);

   psv_pkg::cmd_type  cmd;
   psv_pkg::stat_type stat;

   psv_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   psv_datapath #(
      .MAX_N (MAX_N)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_limit         (req_limit),
      .req_value         (req_value),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_done_res      (rsp_done_res),
      .rsp_is_prime_flag (rsp_is_prime_flag),
      .rsp_prev_prime    (rsp_prev_prime),
      .rsp_out_of_range  (rsp_out_of_range)
   );

endmodule

// ===== tb/prime_sieve_check.sv =====
// response checker for prime_sieve_table: predicts each answer and compares it
module prime_sieve_check #(
   parameter int MAX_N = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic                        req_mode,
   input  logic [psv_pkg::FIELD_W-1:0] req_limit,
   input  logic [psv_pkg::FIELD_W-1:0] req_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_done_res,
   input  logic                        rsp_is_prime_flag,
   input  logic [psv_pkg::FIELD_W-1:0] rsp_prev_prime,
   input  logic                        rsp_out_of_range,
   output int unsigned                 mismatches,
   output int unsigned                 due
);

   typedef struct packed {
      logic                        done;
      logic                        prime;
      logic [psv_pkg::FIELD_W-1:0] prev;
      logic                        oor;
   } answer_type;

   answer_type                  answer_q[$];
   bit                          prime_bits [0:MAX_N];
   logic [psv_pkg::FIELD_W-1:0] sieve_limit;
   bit                          sieve_valid;

   initial begin
      mismatches  = 0;
      due         = 0;
      sieve_valid = 1'b0;
      sieve_limit = '0;
      foreach (prime_bits[i]) prime_bits[i] = 1'b0;
   end

   task automatic build_sieve(input int unsigned top);
      int unsigned i;
      int unsigned j;
      for (i = 0; i <= top; i++) prime_bits[i] = (i >= 2);
      for (i = 2; i * i <= top; i++) begin
         if (prime_bits[i]) begin
            for (j = i * i; j <= top; j += i) prime_bits[j] = 1'b0;
         end
      end
   endtask

   task automatic answer_request(input logic mode, input logic [psv_pkg::FIELD_W-1:0] lim,
                                 input logic [psv_pkg::FIELD_W-1:0] val,
                                 output answer_type ans);
      int unsigned top;
      int unsigned k;
      ans = '0;
      if (mode == psv_pkg::MODE_BUILD) begin
         top = (lim > MAX_N) ? MAX_N : lim;
         build_sieve(top);
         sieve_limit = psv_pkg::FIELD_W'(top);
         sieve_valid = 1'b1;
         ans.done    = 1'b1;
      end else if (!sieve_valid || val > sieve_limit) begin
         ans.oor = 1'b1;
      end else begin
         ans.prime = prime_bits[val];
         k = 32'(val);
         while (k >= 2 && !prime_bits[k]) k--;
         ans.prev = (k >= 2) ? psv_pkg::FIELD_W'(k) : '0;
      end
   endtask

   always @(posedge clock) begin : watch
      answer_type want;
      answer_type fresh;
      if (reset) begin
         sieve_valid = 1'b0;
         sieve_limit = '0;
         answer_q.delete();
      end else begin
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_done_res !== want.done) begin
                  $error("done_res: expected %0d, got %0d", want.done, rsp_done_res);
                  mismatches++;
               end
               if (rsp_is_prime_flag !== want.prime) begin
                  $error("is_prime_flag: expected %0d, got %0d", want.prime, rsp_is_prime_flag);
                  mismatches++;
               end
               if (rsp_prev_prime !== want.prev) begin
                  $error("prev_prime: expected %0d, got %0d", want.prev, rsp_prev_prime);
                  mismatches++;
               end
               if (rsp_out_of_range !== want.oor) begin
                  $error("out_of_range: expected %0d, got %0d", want.oor, rsp_out_of_range);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            answer_request(req_mode, req_limit, req_value, fresh);
            answer_q = {answer_q, fresh};
         end
      end
      due = answer_q.size();
   end

endmodule

// ===== tb/prime_sieve_table_test.sv =====
// testbench top for prime_sieve_table: request stimulus, timeout and verdict
module prime_sieve_table_test;

   localparam int MAX_N           = 4096;
   localparam int CYCLE_LIMIT     = 8000000;
   localparam int RANDOM_REQUESTS = 1700;
   localparam int CALM_TAIL       = 200;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic                        req_mode = psv_pkg::MODE_QUERY;
   logic [psv_pkg::FIELD_W-1:0] req_limit = '0;
   logic [psv_pkg::FIELD_W-1:0] req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_done_res;
   logic                        rsp_is_prime_flag;
   logic [psv_pkg::FIELD_W-1:0] rsp_prev_prime;
   logic                        rsp_out_of_range;
   int unsigned                 mismatches;
   int unsigned                 due;
   int unsigned                 cycles = 0;
   int unsigned                 sieve_top = 0;

   prime_sieve_table #(.MAX_N(MAX_N)) dut (.*);

   prime_sieve_check #(.MAX_N(MAX_N)) sieve_check_i (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("prime_sieve_table_test failed");
         $finish;
      end
   end

   task automatic send_request(input logic mode, input int unsigned lim, input int unsigned val);
      @(negedge clock);
      start     <= 1'b1;
      req_mode  <= mode;
      req_limit <= psv_pkg::FIELD_W'(lim);
      req_value <= psv_pkg::FIELD_W'(val);
      do @(posedge clock); while (busy);
      if (mode == psv_pkg::MODE_BUILD) sieve_top = (lim > MAX_N) ? MAX_N : lim;
   endtask

   task automatic pause_cycles(input int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
         start <= 1'b0;
      end while (due != 0);
   endtask

   task automatic maybe_idle(input int unsigned pct);
      if ($urandom_range(0, 99) < pct) pause_cycles($urandom_range(1, 17));
   endtask

   function automatic int unsigned pick_limit();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return $urandom_range(0, 150);
      else if (r < 88) return $urandom_range(151, 1200);
      else if (r < 96) return $urandom_range(1201, MAX_N);
      else return $urandom_range(MAX_N + 1, 8191);
   endfunction

   function automatic int unsigned pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(0, sieve_top);
      else if (r < 90) return sieve_top + $urandom_range(1, 20);
      else return $urandom_range(0, 8191);
   endfunction

   initial begin
      int unsigned issued;
      int unsigned session;
      int unsigned idle_pct;
      int unsigned queries;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // queries before any build, then tiny and saturated builds
      send_request(psv_pkg::MODE_QUERY, 0, 0);
      send_request(psv_pkg::MODE_QUERY, 8191, 8191);
      send_request(psv_pkg::MODE_BUILD, 0, 0);
      send_request(psv_pkg::MODE_QUERY, 0, 0);
      send_request(psv_pkg::MODE_QUERY, 0, 1);
      send_request(psv_pkg::MODE_BUILD, 1, 0);
      send_request(psv_pkg::MODE_QUERY, 0, 1);
      send_request(psv_pkg::MODE_QUERY, 0, 0);
      send_request(psv_pkg::MODE_BUILD, 2, 0);
      send_request(psv_pkg::MODE_QUERY, 0, 2);
      send_request(psv_pkg::MODE_QUERY, 0, 3);
      send_request(psv_pkg::MODE_BUILD, 8191, 8191);
      send_request(psv_pkg::MODE_QUERY, 0, 4096);
      send_request(psv_pkg::MODE_QUERY, 0, 4093);
      send_request(psv_pkg::MODE_QUERY, 0, 4097);
      send_request(psv_pkg::MODE_QUERY, 0, 8191);
      send_request(psv_pkg::MODE_QUERY, 0, 0);
      send_request(psv_pkg::MODE_QUERY, 0, 1);
      send_request(psv_pkg::MODE_QUERY, 0, 4095);
      send_request(psv_pkg::MODE_QUERY, 0, 2730);
      send_request(psv_pkg::MODE_QUERY, 0, 5461);
      send_request(psv_pkg::MODE_BUILD, 4096, 0);
      send_request(psv_pkg::MODE_QUERY, 0, 2);
      send_request(psv_pkg::MODE_QUERY, 0, 1024);
      wait_drained();

      issued  = 0;
      session = 0;
      while (issued < RANDOM_REQUESTS) begin
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 50;
         endcase
         if (($urandom_range(0, 2) == 0 || session == 10) &&
             issued + CALM_TAIL < RANDOM_REQUESTS) wait_drained();
         send_request(psv_pkg::MODE_BUILD, pick_limit(), $urandom_range(0, 8191));
         issued++;
         queries = $urandom_range(10, 60);
         repeat (queries) begin
            maybe_idle((issued + CALM_TAIL >= RANDOM_REQUESTS) ? 0 : idle_pct);
            send_request(psv_pkg::MODE_QUERY, $urandom_range(0, 8191), pick_value());
            issued++;
         end
         session++;
      end

      wait_drained();
      pause_cycles(40);
      if (mismatches == 0 && due == 0) begin
         $display("prime_sieve_table_test passed");
      end else begin
         $display("prime_sieve_table_test failed");
      end
      $finish;
   end

endmodule
